[sv/hdt_pkg.sv]
// Shared types, constants and helpers for the haptic dial torque block.
package hdt_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int TERM_W    = 51;
    localparam int ACC_W     = 37;
    localparam int DIV_W     = 34;
    localparam int DIV_CYCLES = DIV_W / 2;
    localparam int DCNT_W    = $clog2(DIV_CYCLES);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TLIM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TGAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BANGLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BGAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE  = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_QD, S_DERR, S_DMUL, S_DACC,
        S_TPMUL, S_TDMUL, S_TACC, S_BMUL, S_BACC, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        MS_QD, MS_DET, MS_TP, MS_TD, MS_BND
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     derr;
        logic     acc_det;
        logic     tp_hold;
        logic     acc_trk;
        logic     acc_bnd;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic det_go;
        logic trk_en;
        logic bnd_en;
        logic div_last;
        logic out_free;
    } t_dp_status;

    // Clamp a signed term to plus or minus an unsigned limit
    function automatic logic signed [TERM_W-1:0] clamp_sym(
        input logic signed [TERM_W-1:0] t,
        input logic [DATA_W-1:0]        lim
    );
        logic signed [TERM_W-1:0] l;
        l = $signed({{(TERM_W-DATA_W){1'b0}}, lim});
        if (t > l) begin
            return l;
        end
        if (t < -l) begin
            return -l;
        end
        return t;
    endfunction

endpackage

[sv/hdt_ctrl.sv]
// Sequencer that steps the datapath through the torque terms of one item.
module hdt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hdt_pkg::t_dp_status i_status,
    output hdt_pkg::t_dp_cmd    o_cmd
);
    import hdt_pkg::*;

    t_state r_state, n_state;
    t_state after_det, after_trk;

    // Pick the next enabled term
    always_comb begin
        after_trk = i_status.bnd_en ? S_BMUL : S_FIN;
        after_det = i_status.trk_en ? S_TPMUL : after_trk;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) begin
                n_state = i_status.det_go ? S_DIV : after_det;
            end
            S_DIV:   if (i_status.div_last) begin
                n_state = S_QD;
            end
            S_QD:    n_state = S_DERR;
            S_DERR:  n_state = S_DMUL;
            S_DMUL:  n_state = S_DACC;
            S_DACC:  n_state = after_det;
            S_TPMUL: n_state = S_TDMUL;
            S_TDMUL: n_state = S_TACC;
            S_TACC:  n_state = after_trk;
            S_BMUL:  n_state = S_BACC;
            S_BACC:  n_state = S_FIN;
            S_FIN:   if (i_status.out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_cmd.mul_sel = MS_QD;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV:   o_cmd.div_step = 1'b1;
            S_QD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_QD;
            end
            S_DERR:  o_cmd.derr = 1'b1;
            S_DMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DET;
            end
            S_DACC:  o_cmd.acc_det = 1'b1;
            S_TPMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_TP;
            end
            S_TDMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_TD;
                o_cmd.tp_hold = 1'b1;
            end
            S_TACC:  o_cmd.acc_trk = 1'b1;
            S_BMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_BND;
            end
            S_BACC:  o_cmd.acc_bnd = 1'b1;
            S_FIN:   o_cmd.finish = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/hdt_datapath.sv]
// Configuration registers, divider, shared multiplier, accumulator and output register.
module hdt_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [hdt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hdt_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [hdt_pkg::DATA_W-1:0] i_angle,
    input  logic signed [hdt_pkg::DATA_W-1:0] i_speed,
    input  logic [hdt_pkg::DATA_W-1:0]        i_now_ms,
    input  logic                              i_resync,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [hdt_pkg::DATA_W-1:0] o_torque,
    output logic                              o_out_of_bounds,
    input  hdt_pkg::t_dp_cmd                  i_cmd,
    output hdt_pkg::t_dp_status               o_status
);
    import hdt_pkg::*;

    localparam int SH_W = 2 * DATA_W - FRAC_BITS;

    // Configuration registers
    logic [4:0]        r_mode;
    logic [CFG_W-1:0]  r_dsg, r_tlim, r_tgain, r_bang, r_bgl, r_pulse;
    logic [DATA_W-1:0] r_target;

    // Item registers
    logic signed [DATA_W-1:0] r_angle, r_speed;
    logic [DATA_W-1:0]        r_now;
    logic                     r_resync, r_above, r_oob;
    logic [DATA_W:0]          r_terr_mag, r_bmag, r_derr_mag;
    logic                     r_terr_neg, r_derr_neg;

    // Divider, multiplier, accumulator
    logic [DIV_W-1:0]         r_dq, r_rem;
    logic [DCNT_W-1:0]        r_dcnt;
    logic [2*DATA_W-1:0]      r_prod;
    logic                     r_pneg;
    logic signed [TERM_W-1:0] r_tp;
    logic signed [ACC_W-1:0]  r_acc;

    // Pulse state and output
    logic [DATA_W-1:0]        r_vlast, r_klast;
    logic                     r_kon;
    logic                     r_out_valid;

    logic [DATA_W-1:0] spacing;
    assign spacing = r_dsg[63:32];

    // Status
    assign o_status.det_go   = r_mode[0] && (spacing != '0);
    assign o_status.trk_en   = r_mode[1];
    assign o_status.bnd_en   = r_mode[3];
    assign o_status.div_last = (r_dcnt == DCNT_W'(DIV_CYCLES - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_dsg    <= '0;
            r_tlim   <= '0;
            r_target <= '0;
            r_tgain  <= '0;
            r_bang   <= '0;
            r_bgl    <= '0;
            r_pulse  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[4:0];
                CFG_DETENT: r_dsg    <= i_cfg_data;
                CFG_TLIM:   r_tlim   <= i_cfg_data;
                CFG_TARGET: r_target <= i_cfg_data[DATA_W-1:0];
                CFG_TGAIN:  r_tgain  <= i_cfg_data;
                CFG_BANGLE: r_bang   <= i_cfg_data;
                CFG_BGAIN:  r_bgl    <= i_cfg_data;
                CFG_PULSE:  r_pulse  <= i_cfg_data;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    // Load-time errors: angle magnitude, tracking error, bounds overshoot
    logic [DATA_W-1:0]        amag;
    logic signed [DATA_W:0]   terr;
    logic signed [DATA_W-1:0] bmin, bmax;
    logic                     above, below;
    logic signed [DATA_W:0]   berr;
    always_comb begin
        amag  = i_angle[DATA_W-1] ? (~i_angle + 1'b1) : i_angle;
        terr  = $signed({r_target[DATA_W-1], r_target}) - $signed({i_angle[DATA_W-1], i_angle});
        bmin  = $signed(r_bang[63:32]);
        bmax  = $signed(r_bang[31:0]);
        above = i_angle > bmax;
        below = i_angle < bmin;
        if (above) begin
            berr = $signed({i_angle[DATA_W-1], i_angle}) - $signed({bmax[DATA_W-1], bmax});
        end else if (below) begin
            berr = $signed({bmin[DATA_W-1], bmin}) - $signed({i_angle[DATA_W-1], i_angle});
        end else begin
            berr = '0;
        end
    end

    // Divider: two restoring steps per cycle
    logic [DIV_W-1:0] den, st_rem, st_dq, rem_sh;
    always_comb begin
        den    = {1'b0, spacing, 1'b0};
        st_rem = r_rem;
        st_dq  = r_dq;
        rem_sh = '0;
        for (int k = 0; k < 2; k++) begin
            rem_sh = {st_rem[DIV_W-2:0], st_dq[DIV_W-1]};
            st_dq  = {st_dq[DIV_W-2:0], 1'b0};
            if (rem_sh >= den) begin
                st_rem   = rem_sh - den;
                st_dq[0] = 1'b1;
            end else begin
                st_rem = rem_sh;
            end
        end
    end

    // Shared multiplier operand select
    logic [DATA_W-1:0]   ma;
    logic [DATA_W:0]     mb;
    logic                mneg;
    logic [DATA_W-1:0]   smag;
    logic [2*DATA_W:0]   full;
    always_comb begin
        smag = r_speed[DATA_W-1] ? (~r_speed + 1'b1) : r_speed;
        case (i_cmd.mul_sel)
            MS_QD: begin
                ma = spacing;          mb = r_dq[DATA_W:0];   mneg = 1'b0;
            end
            MS_DET: begin
                ma = r_dsg[31:0];      mb = r_derr_mag;       mneg = r_derr_neg;
            end
            MS_TP: begin
                ma = r_tgain[63:32];   mb = r_terr_mag;       mneg = r_terr_neg;
            end
            MS_TD: begin
                ma = r_tgain[31:0];    mb = {1'b0, smag};     mneg = r_speed[DATA_W-1];
            end
            default: begin
                ma = r_bgl[63:32];     mb = r_bmag;           mneg = 1'b0;
            end
        endcase
        full = {{(DATA_W+1){1'b0}}, ma} * {{DATA_W{1'b0}}, mb};
    end

    // Scaled product with its sign
    logic [SH_W-1:0]          sh;
    logic signed [TERM_W-1:0] sv, tsum, cl;
    logic signed [DATA_W+2:0] snear, derr;
    logic [DATA_W+2:0]        dmag;
    always_comb begin
        sh    = r_prod[2*DATA_W-1:FRAC_BITS];
        sv    = r_pneg ? -$signed(TERM_W'(sh)) : $signed(TERM_W'(sh));
        tsum  = r_tp - sv;
        snear = r_angle[DATA_W-1] ? -$signed({2'b0, r_prod[DATA_W:0]})
                                  : $signed({2'b0, r_prod[DATA_W:0]});
        derr  = snear - $signed({{3{r_angle[DATA_W-1]}}, r_angle});
        dmag  = derr[DATA_W+2] ? -derr : derr;
        cl    = '0;
        if (i_cmd.acc_det) begin
            cl = clamp_sym(sv, r_tlim[63:32]);
        end else if (i_cmd.acc_trk) begin
            cl = clamp_sym(tsum, r_tlim[31:0]);
        end else begin
            cl = ($signed(TERM_W'(sh)) > $signed(TERM_W'(r_bgl[31:0])))
                 ? $signed(TERM_W'(r_bgl[31:0])) : $signed(TERM_W'(sh));
            cl = r_above ? -cl : cl;
        end
    end

    // Pulse terms, timers and saturation
    logic [DATA_W-1:0]       n_vlast, n_klast;
    logic                    n_kon;
    logic signed [ACC_W-1:0] total, vamp, kamp;
    logic signed [DATA_W-1:0] n_torque;
    always_comb begin
        n_vlast = r_resync ? r_now : r_vlast;
        n_klast = r_resync ? r_now : r_klast;
        n_kon   = r_resync ? 1'b0 : r_kon;
        total   = r_acc;
        vamp    = ACC_W'($signed(r_pulse[31:16])) <<< (FRAC_BITS - 8);
        kamp    = ACC_W'($signed(r_pulse[15:0])) <<< (FRAC_BITS - 8);
        if (r_mode[2]) begin
            if ((r_now - n_vlast) >= DATA_W'(r_pulse[63:48])) begin
                n_vlast = r_now;
                total   = total + vamp;
            end
        end
        if (r_mode[4] && r_oob) begin
            if ((r_now - n_klast) >= DATA_W'(r_pulse[47:32])) begin
                n_klast = r_now;
                n_kon   = !n_kon;
            end
            if (n_kon) begin
                total = r_above ? (total + kamp) : (total - kamp);
            end
        end
        if (total > $signed(ACC_W'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            n_torque = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (total < -$signed(ACC_W'({1'b1, {(DATA_W-1){1'b0}}}))) begin
            n_torque = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_torque = total[DATA_W-1:0];
        end
    end

    // Item datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_angle    <= i_angle;
            r_speed    <= i_speed;
            r_now      <= i_now_ms;
            r_resync   <= i_resync;
            r_above    <= above;
            r_oob      <= above || below;
            r_terr_neg <= terr[DATA_W];
            r_terr_mag <= terr[DATA_W] ? DATA_W'(0) - terr : terr;
            r_bmag     <= berr;
            r_dq       <= {1'b0, amag, 1'b0} + {2'b0, spacing};
            r_rem      <= '0;
            r_acc      <= '0;
        end
        if (i_cmd.div_step) begin
            r_dq  <= st_dq;
            r_rem <= st_rem;
        end
        if (i_cmd.mul_en) begin
            r_prod <= full[2*DATA_W-1:0];
            r_pneg <= mneg;
        end
        if (i_cmd.derr) begin
            r_derr_neg <= derr[DATA_W+2];
            r_derr_mag <= dmag[DATA_W:0];
        end
        if (i_cmd.tp_hold) begin
            r_tp <= sv;
        end
        if (i_cmd.acc_det || i_cmd.acc_trk || i_cmd.acc_bnd) begin
            r_acc <= r_acc + ACC_W'(cl);
        end
        if (i_cmd.finish) begin
            o_torque        <= n_torque;
            o_out_of_bounds <= r_oob;
        end
    end

    // Divider step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.load) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // Timer state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlast     <= '0;
            r_klast     <= '0;
            r_kon       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_vlast     <= n_vlast;
                r_klast     <= n_klast;
                r_kon       <= n_kon;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/haptic_dial_torque.sv]
// Top level of the haptic dial torque block.
// Input channel (i_in_valid / o_in_ready) carries angle, speed, millisecond time
// and a resync flag; one item gives exactly one result on the output channel
// (o_out_valid / i_out_ready): a saturated Q16.16 torque and an out-of-bounds flag.
// Configuration registers are written on the cfg channel (index, 64-bit data),
// which is always ready; write them only while the block is idle.
// One item is worked at a time. With all terms off the sequencer goes straight
// to its finish step; with detent, tracking and bounds on, the detent term
// runs a divider (two quotient bits a cycle) for the nearest detent, then each
// gain product goes through one shared 32x33 multiplier, one product a cycle,
// each term followed by an accumulate step. The next item can be accepted in
// the cycle after the result is written. The previous result may still wait in
// the output register; if the receiver stalls, the sequencer holds its last step
// until the output register frees.
// Synchronous active-low reset clears all configuration registers, the pulse
// timers and the kick toggle, and empties the output register.
module haptic_dial_torque (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hdt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hdt_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [hdt_pkg::DATA_W-1:0] i_angle,
    input  logic signed [hdt_pkg::DATA_W-1:0] i_speed,
    input  logic [hdt_pkg::DATA_W-1:0]        i_now_ms,
    input  logic                              i_resync,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [hdt_pkg::DATA_W-1:0] o_torque,
    output logic                              o_out_of_bounds
);
    import hdt_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    hdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hdt_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_angle         (i_angle),
        .i_speed         (i_speed),
        .i_now_ms        (i_now_ms),
        .i_resync        (i_resync),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_torque        (o_torque),
        .o_out_of_bounds (o_out_of_bounds),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule
